// ----- src/gbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy box suppression package
// Shared sizes, the stored box record and the controller/datapath interface.
// ----------------------------------------------------------------------------
package gbs_pkg;

  localparam int unsigned MAX_KEPT  = 64;
  localparam int unsigned MAX_BOXES = 8192;

  localparam int unsigned KEPT_AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_KEPT + 1);

  localparam int unsigned COORD_W = 16;
  localparam int unsigned LEN_W   = 15;
  localparam int unsigned AREA_W  = 2 * LEN_W;
  localparam int unsigned UNI_W   = AREA_W + 1;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned PROD_W  = THR_W + UNI_W;
  localparam int unsigned IDX_W   = 13;

  localparam int unsigned INDEX_TOP_INT = ((MAX_BOXES - 1) < 8191) ? (MAX_BOXES - 1) : 8191;
  localparam logic [IDX_W-1:0] INDEX_TOP = IDX_W'(INDEX_TOP_INT);

  localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic [LEN_W-1:0]          width;
    logic [LEN_W-1:0]          height;
  } gbs_box_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic commit;
  } gbs_cmd_t;

  typedef struct packed {
    logic all_issued;
    logic pipe_busy;
  } gbs_status_t;

endpackage

// ----- src/gbs_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy box suppression controller
// Sequences acceptance, the comparison sweep and the result hand-off.
// ----------------------------------------------------------------------------
module gbs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  gbs_pkg::gbs_status_t status_i,
  output gbs_pkg::gbs_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_REPORT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        cmd_o.issue = !status_i.all_issued;
        if (status_i.all_issued && !status_i.pipe_busy) begin
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: begin
        // The result register is loaded only once the previous result has left.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- src/gbs_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy box suppression datapath
// Kept-box memory, overlap pipeline, counters and result registers.
// ----------------------------------------------------------------------------
module gbs_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gbs_pkg::THR_W-1:0]           cfg_data_i,
  input  logic signed [gbs_pkg::COORD_W-1:0]  left_edge_i,
  input  logic signed [gbs_pkg::COORD_W-1:0]  top_edge_i,
  input  logic [gbs_pkg::LEN_W-1:0]           box_width_i,
  input  logic [gbs_pkg::LEN_W-1:0]           box_height_i,
  input  logic                                first_box_i,
  input  gbs_pkg::gbs_cmd_t                   cmd_i,
  output gbs_pkg::gbs_status_t                status_o,
  output logic [gbs_pkg::IDX_W-1:0]           box_index_o,
  output logic                                keep_o,
  output logic                                store_overflow_o
);

  // Length of the overlap of two intervals, zero when they only touch or miss.
  function automatic logic [gbs_pkg::LEN_W-1:0] overlap_len(
    input logic signed [gbs_pkg::COORD_W-1:0] a0,
    input logic [gbs_pkg::LEN_W-1:0]          alen,
    input logic signed [gbs_pkg::COORD_W-1:0] b0,
    input logic [gbs_pkg::LEN_W-1:0]          blen
  );
    logic signed [gbs_pkg::COORD_W:0]   a1;
    logic signed [gbs_pkg::COORD_W:0]   b1;
    logic signed [gbs_pkg::COORD_W:0]   lo;
    logic signed [gbs_pkg::COORD_W:0]   hi;
    logic signed [gbs_pkg::COORD_W+1:0] diff;
    a1   = $signed({a0[gbs_pkg::COORD_W-1], a0}) + $signed({2'b00, alen});
    b1   = $signed({b0[gbs_pkg::COORD_W-1], b0}) + $signed({2'b00, blen});
    lo   = (a0 > b0) ? $signed({a0[gbs_pkg::COORD_W-1], a0})
                     : $signed({b0[gbs_pkg::COORD_W-1], b0});
    hi   = (a1 < b1) ? a1 : b1;
    diff = $signed({hi[gbs_pkg::COORD_W], hi}) - $signed({lo[gbs_pkg::COORD_W], lo});
    return (diff > 0) ? diff[gbs_pkg::LEN_W-1:0] : '0;
  endfunction

  gbs_pkg::gbs_box_t kept_mem [gbs_pkg::MAX_KEPT];

  logic [gbs_pkg::THR_W-1:0]  thr_q;
  gbs_pkg::gbs_box_t          nb_q;
  logic [gbs_pkg::AREA_W-1:0] an_q;
  logic [gbs_pkg::CNT_W-1:0]  kept_count_q;
  logic [gbs_pkg::CNT_W-1:0]  rd_addr_q;
  logic [gbs_pkg::IDX_W-1:0]  next_index_q;
  logic [gbs_pkg::IDX_W-1:0]  cur_index_q;
  logic [gbs_pkg::IDX_W-1:0]  idx_base;
  logic                       supp_q;
  logic                       keep_now;
  logic                       room;

  // Comparison pipeline.
  gbs_pkg::gbs_box_t          rd_box_q;
  logic                       v0_q, va_q, vb_q, vc_q, vd_q;
  logic [gbs_pkg::LEN_W-1:0]  iw_q, ih_q;
  logic [gbs_pkg::AREA_W-1:0] ak_q;
  logic [gbs_pkg::AREA_W-1:0] inter_b_q, inter_c_q, inter_d_q;
  logic [gbs_pkg::UNI_W-1:0]  sum_q;
  logic [gbs_pkg::UNI_W-1:0]  uni_q;
  logic [gbs_pkg::PROD_W-1:0] prod_q;
  logic                       uni_zero_q;

  assign idx_base = first_box_i ? '0 : next_index_q;
  assign keep_now = !supp_q;
  assign room     = (kept_count_q < gbs_pkg::CNT_W'(gbs_pkg::MAX_KEPT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= gbs_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_count_q <= '0;
      next_index_q <= '0;
      rd_addr_q    <= '0;
      supp_q       <= 1'b0;
      v0_q         <= 1'b0;
      va_q         <= 1'b0;
      vb_q         <= 1'b0;
      vc_q         <= 1'b0;
      vd_q         <= 1'b0;
    end else begin
      v0_q <= cmd_i.issue;
      va_q <= v0_q;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      if (cmd_i.accept) begin
        rd_addr_q    <= '0;
        supp_q       <= 1'b0;
        next_index_q <= (idx_base < gbs_pkg::INDEX_TOP) ? idx_base + 1'b1 : idx_base;
        if (first_box_i) begin
          kept_count_q <= '0;
        end
      end else begin
        if (cmd_i.issue) begin
          rd_addr_q <= rd_addr_q + 1'b1;
        end
        if (vd_q && !uni_zero_q &&
            ({1'b0, inter_d_q, 16'b0} > prod_q)) begin
          supp_q <= 1'b1;
        end
        if (cmd_i.commit && keep_now && room) begin
          kept_count_q <= kept_count_q + 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      nb_q.left   <= left_edge_i;
      nb_q.top    <= top_edge_i;
      nb_q.width  <= box_width_i;
      nb_q.height <= box_height_i;
      cur_index_q <= idx_base;
    end
    an_q <= nb_q.width * nb_q.height;
    if (cmd_i.commit) begin
      box_index_o      <= cur_index_q;
      keep_o           <= keep_now;
      store_overflow_o <= keep_now && !room;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && keep_now && room) begin
      kept_mem[kept_count_q[gbs_pkg::KEPT_AW-1:0]] <= nb_q;
    end
    if (cmd_i.issue) begin
      rd_box_q <= kept_mem[rd_addr_q[gbs_pkg::KEPT_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    iw_q       <= overlap_len(nb_q.left, nb_q.width, rd_box_q.left, rd_box_q.width);
    ih_q       <= overlap_len(nb_q.top, nb_q.height, rd_box_q.top, rd_box_q.height);
    ak_q       <= rd_box_q.width * rd_box_q.height;
    inter_b_q  <= iw_q * ih_q;
    sum_q      <= {1'b0, an_q} + {1'b0, ak_q};
    inter_c_q  <= inter_b_q;
    uni_q      <= sum_q - {1'b0, inter_b_q};
    inter_d_q  <= inter_c_q;
    prod_q     <= thr_q * uni_q;
    uni_zero_q <= (uni_q == '0);
  end

  assign status_o.all_issued = (rd_addr_q == kept_count_q);
  assign status_o.pipe_busy  = v0_q || va_q || vb_q || vc_q || vd_q;

endmodule

// ----- src/greedy_box_suppression_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy box suppression core
// Overlap-ratio suppression of score-sorted boxes against a list of kept boxes.
// ----------------------------------------------------------------------------
// The single read port of the kept-box memory gives one comparison per cycle. A
// result is loaded only once a stalled earlier result has left the output register.
// Reset: asynchronous, active low; clears the kept count, the box index and the
// handshake state, loads the threshold with 29491.
//
// Operation: the controller accepts a request only while idle. On acceptance the
// datapath captures the box, assigns its index (a first box restarts both the index
// and the kept list) and then sweeps the kept list, reading one stored box per
// cycle into a five-stage pipeline. The stages form the clipped intersection
// lengths, the intersection and union areas, the threshold product, and finally
// compare intersection * 65536 against threshold * union. Any hit sets a sticky
// suppression flag. Once the pipeline has drained, the result is loaded into the
// output register; a surviving box is written to the next free memory entry, or
// flagged as overflow when the list is full. The output register lets the result
// wait while the next request is already being accepted.
module greedy_box_suppression_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gbs_pkg::THR_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [gbs_pkg::COORD_W-1:0]  left_edge_i,
  input  logic signed [gbs_pkg::COORD_W-1:0]  top_edge_i,
  input  logic [gbs_pkg::LEN_W-1:0]           box_width_i,
  input  logic [gbs_pkg::LEN_W-1:0]           box_height_i,
  input  logic                                first_box_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [gbs_pkg::IDX_W-1:0]           box_index_o,
  output logic                                keep_o,
  output logic                                store_overflow_o
);

  gbs_pkg::gbs_cmd_t    cmd;
  gbs_pkg::gbs_status_t status;

  gbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gbs_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .left_edge_i      (left_edge_i),
    .top_edge_i       (top_edge_i),
    .box_width_i      (box_width_i),
    .box_height_i     (box_height_i),
    .first_box_i      (first_box_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .box_index_o      (box_index_o),
    .keep_o           (keep_o),
    .store_overflow_o (store_overflow_o)
  );

  // A result must never overwrite one that is still waiting to be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> !(out_valid_o && out_stall_i))
    else $error("result register loaded while the previous result was stalled");

  // A new request must not arrive while comparisons are still in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.pipe_busy |-> in_stall_o)
    else $error("input not stalled while the comparison pipeline is busy");

  // Each accepted request occupies the core until its result is reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second request accepted straight after the first");

  // Issuing and committing are never requested together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.issue && cmd.commit))
    else $error("memory read issued during result commit");

endmodule
